// ----- rtl/mpsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants for the multi-pattern score matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int NODES_DEF   = 256;
    localparam int SYMBOLS_DEF = 4;
    localparam int SCORE_W     = 20;
    localparam int TOTAL_W     = 32;

    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_BUILD   = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [1:0] KIND_TOTAL = 2'd0;
    localparam logic [1:0] KIND_BUILT = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         symbol;
        logic               pattern_end;
        logic [SCORE_W-1:0] pattern_score;
        logic               text_last;
    } req_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [TOTAL_W-1:0] total_score;
    } rsp_t;

    typedef struct packed {
        logic active;
        logic last;
    } sweep_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS,
        ST_W_RD,
        ST_W_CK,
        ST_W_FL,
        ST_T_SC,
        ST_B_R_RD,
        ST_B_R_CK,
        ST_B_Q,
        ST_B_QW,
        ST_B_FW,
        ST_B_C_RD,
        ST_B_C_CK,
        ST_B_TM
    } state_t;

endpackage

// ----- rtl/multi_pattern_score_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_score_matcher
// Aho-Corasick style multi-pattern matcher with per-pattern scores.
// ----------------------------------------------------------------------------
// The trie lives in synchronous RAMs: a goto table of NODES*SYMBOLS entries,
// a failure link table, a node table holding the terminal mark and score, and
// the breadth-first queue used while building the links. After reset, and
// after every clear transaction, the block sweeps the tables over
// NODES*SYMBOLS addresses (1024 at the default size) and accepts nothing
// until the sweep ends. Every step of the failure walk for a text symbol is
// a dependent read of the goto and failure link RAMs. A build first links
// the children of the root, then takes the queued nodes in breadth-first
// order and walks the failure links for each child. A result is held in an
// output register, so the next transaction may be accepted while it waits
// to be taken.
// ----------------------------------------------------------------------------
module multi_pattern_score_matcher
    import mpsm_pkg::*;
#(
    parameter int NODES   = NODES_DEF,
    parameter int SYMBOLS = SYMBOLS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(SYMBOLS);
    localparam int GD    = NODES * SYMBOLS;
    localparam int AW    = $clog2(GD);
    localparam int NDW   = SCORE_W + 1;

    // Goto table address of a node and symbol.
    function automatic logic [AW-1:0] gaddr(input logic [NW-1:0] node,
                                            input logic [SW-1:0] s);
        return AW'(node) * AW'(SYMBOLS) + AW'(s);
    endfunction

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [NW:0]        count_reg, count_next;
    logic [NW-1:0]      cursor_reg, cursor_next;
    logic [NW-1:0]      match_reg, match_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [NW-1:0]      head_reg, head_next;
    logic [NW-1:0]      tail_reg, tail_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      cur_reg, cur_next;
    logic [NW-1:0]      fc_reg, fc_next;
    logic [NW-1:0]      child_reg, child_next;
    logic [SW-1:0]      s_reg, s_next;
    logic               symok_reg, symok_next;
    logic               build_reg, build_next;
    logic               hit_reg, hit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // RAM ports.
    logic           g_we;
    logic [AW-1:0]  g_waddr, g_raddr;
    logic [NW-1:0]  g_wdata, g_rdata;
    logic           f_we;
    logic [NW-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
    logic           d_we;
    logic [NW-1:0]  d_waddr, d_raddr;
    logic [NDW-1:0] d_wdata, d_rdata;
    logic           q_we;
    logic [NW-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

    sweep_stat_t    sw_stat;
    logic [AW-1:0]  sw_addr;
    logic           sw_start;

    logic           accept;
    logic           slot_free;
    logic           s_last;
    logic           full;
    logic [NW-1:0]  cw;
    logic [NW-1:0]  walk_res;
    logic           walk_more;
    logic [TOTAL_W:0] sum;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign s_last    = (s_reg == SW'(SYMBOLS - 1));
    assign full      = (count_reg == (NW + 1)'(NODES));

    // Child seen by the failure walk; a symbol outside the alphabet has none.
    assign cw        = symok_reg ? g_rdata : '0;
    assign walk_more = (cw == '0) && (n_reg != '0);
    assign walk_res  = (cw != '0) ? cw : n_reg;
    assign sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(d_rdata[SCORE_W-1:0]);

    mpsm_sweep #(.DEPTH(GD)) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sw_start),
        .stat  (sw_stat),
        .addr  (sw_addr)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
        .clk (clk), .we (g_we), .waddr (g_waddr), .wdata (g_wdata),
        .raddr (g_raddr), .rdata (g_rdata)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
        .clk (clk), .we (f_we), .waddr (f_waddr), .wdata (f_wdata),
        .raddr (f_raddr), .rdata (f_rdata)
    );

    mpsm_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node (
        .clk (clk), .we (d_we), .waddr (d_waddr), .wdata (d_wdata),
        .raddr (d_raddr), .rdata (d_rdata)
    );

    mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
        .clk (clk), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
        .raddr (q_raddr), .rdata (q_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sw_stat.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_PATTERN:
                            state_next = (32'(req.symbol) < SYMBOLS) ? ST_INS : ST_IDLE;
                        CMD_BUILD:   state_next = ST_B_R_RD;
                        CMD_TEXT:    state_next = ST_W_CK;
                        default:     state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_INS:
            begin
                if (!(g_rdata == '0 && full && !slot_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_W_RD: state_next = ST_W_CK;
            ST_W_CK:
            begin
                if (walk_more)
                begin
                    state_next = ST_W_FL;
                end
                else
                begin
                    state_next = build_reg ? ST_B_TM : ST_T_SC;
                end
            end
            ST_W_FL: state_next = ST_W_RD;
            ST_T_SC:
            begin
                if (!(req_reg.text_last && !slot_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_B_R_RD: state_next = ST_B_R_CK;
            ST_B_R_CK: state_next = s_last ? ST_B_Q : ST_B_R_RD;
            ST_B_Q:
            begin
                if (head_reg != tail_reg)
                begin
                    state_next = ST_B_QW;
                end
                else if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_B_QW:   state_next = ST_B_FW;
            ST_B_FW:   state_next = ST_B_C_RD;
            ST_B_C_RD: state_next = ST_B_C_CK;
            ST_B_C_CK:
            begin
                if (g_rdata != '0)
                begin
                    state_next = ST_W_RD;
                end
                else
                begin
                    state_next = s_last ? ST_B_Q : ST_B_C_RD;
                end
            end
            ST_B_TM:   state_next = s_last ? ST_B_Q : ST_B_C_RD;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Datapath, RAM control and register updates.
    always_comb
    begin
        req_next       = req_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        match_next     = match_reg;
        total_next     = total_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        fc_next        = fc_reg;
        child_next     = child_reg;
        s_next         = s_reg;
        symok_next     = symok_reg;
        build_next     = build_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        sw_start       = 1'b0;

        g_we = 1'b0; g_waddr = gaddr(cursor_reg, SW'(req_reg.symbol)); g_wdata = '0;
        g_raddr = gaddr(n_reg, s_reg);
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = n_reg;
        d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = walk_res;
        q_we = 1'b0; q_waddr = tail_reg; q_wdata = '0; q_raddr = head_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = sw_addr;
                f_we    = 1'b1;
                f_waddr = sw_addr[NW-1:0];
                d_we    = 1'b1;
                d_waddr = sw_addr[NW-1:0];
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    case (req.cmd)
                        CMD_PATTERN:
                            g_raddr = gaddr(cursor_reg, SW'(req.symbol));
                        CMD_BUILD:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            s_next     = '0;
                            symok_next = 1'b1;
                            build_next = 1'b1;
                        end
                        CMD_TEXT:
                        begin
                            g_raddr    = gaddr(match_reg, SW'(req.symbol));
                            n_next     = match_reg;
                            s_next     = SW'(req.symbol);
                            symok_next = (32'(req.symbol) < SYMBOLS);
                            build_next = 1'b0;
                        end
                        default:
                        begin
                            sw_start    = 1'b1;
                            count_next  = (NW + 1)'(1);
                            cursor_next = '0;
                            match_next  = '0;
                            total_next  = '0;
                            head_next   = '0;
                            tail_next   = '0;
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                // Keep reading the same goto entry while the report waits.
                g_raddr = gaddr(cursor_reg, SW'(req_reg.symbol));
                if (g_rdata == '0 && full)
                begin
                    // Table full: drop the symbol and report it.
                    if (slot_free)
                    begin
                        cursor_next    = '0;
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{result_kind: KIND_FULL, total_score: '0};
                    end
                end
                else
                begin
                    cursor_next = (g_rdata == '0) ? count_reg[NW-1:0] : g_rdata;
                    if (g_rdata == '0)
                    begin
                        g_we       = 1'b1;
                        g_wdata    = count_reg[NW-1:0];
                        count_next = count_reg + (NW + 1)'(1);
                    end
                    if (req_reg.pattern_end)
                    begin
                        d_we        = 1'b1;
                        d_waddr     = (g_rdata == '0) ? count_reg[NW-1:0] : g_rdata;
                        d_wdata     = {1'b1, req_reg.pattern_score};
                        cursor_next = '0;
                    end
                end
            end
            ST_W_CK:
            begin
                if (walk_more)
                begin
                    f_raddr = n_reg;
                end
                else
                begin
                    n_next   = walk_res;
                    hit_next = (cw != '0);
                    if (build_reg)
                    begin
                        f_we    = 1'b1;
                        f_waddr = child_reg;
                        f_wdata = walk_res;
                    end
                    else
                    begin
                        match_next = walk_res;
                    end
                end
            end
            ST_W_FL:
            begin
                n_next = f_rdata;
            end
            ST_T_SC:
            begin
                // The matched node sits in n_reg; hold its entry while stalled.
                d_raddr = n_reg;
                if (!(req_reg.text_last && !slot_free))
                begin
                    if (hit_reg && d_rdata[SCORE_W])
                    begin
                        total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    end
                    if (req_reg.text_last)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{result_kind: KIND_TOTAL,
                                           total_score: (hit_reg && d_rdata[SCORE_W]) ?
                                               (sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0]) :
                                               total_reg};
                        total_next     = '0;
                        match_next     = '0;
                    end
                end
            end
            ST_B_R_RD:
            begin
                g_raddr = gaddr('0, s_reg);
            end
            ST_B_R_CK:
            begin
                // Children of the root fail to the root.
                if (g_rdata != '0)
                begin
                    f_we      = 1'b1;
                    f_waddr   = g_rdata;
                    q_we      = 1'b1;
                    q_wdata   = g_rdata;
                    tail_next = tail_reg + NW'(1);
                end
                s_next = s_reg + SW'(1);
            end
            ST_B_Q:
            begin
                if (head_reg != tail_reg)
                begin
                    q_raddr   = head_reg;
                    head_next = head_reg + NW'(1);
                end
                else if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{result_kind: KIND_BUILT, total_score: '0};
                end
            end
            ST_B_QW:
            begin
                cur_next = q_rdata;
                f_raddr  = q_rdata;
            end
            ST_B_FW:
            begin
                fc_next = f_rdata;
                s_next  = '0;
            end
            ST_B_C_RD:
            begin
                g_raddr = gaddr(cur_reg, s_reg);
            end
            ST_B_C_CK:
            begin
                if (g_rdata != '0)
                begin
                    child_next = g_rdata;
                    n_next     = fc_reg;
                end
                else
                begin
                    s_next = s_reg + SW'(1);
                end
            end
            ST_B_TM:
            begin
                // A child whose failure target is terminal takes its mark and score.
                if (d_rdata[SCORE_W])
                begin
                    d_we    = 1'b1;
                    d_waddr = child_reg;
                    d_wdata = d_rdata;
                end
                q_we      = 1'b1;
                q_wdata   = child_reg;
                tail_next = tail_reg + NW'(1);
                s_next    = s_reg + SW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= (NW + 1)'(1);
            cursor_reg    <= '0;
            match_reg     <= '0;
            total_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            build_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            match_reg     <= match_next;
            total_reg     <= total_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            build_reg     <= build_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        n_reg     <= n_next;
        cur_reg   <= cur_next;
        fc_reg    <= fc_next;
        child_reg <= child_next;
        s_reg     <= s_next;
        symok_reg <= symok_next;
        hit_reg   <= hit_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/mpsm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/mpsm_sweep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_sweep
// Address sweep that clears the tables after reset and on a clear command.
// ----------------------------------------------------------------------------
module mpsm_sweep
    import mpsm_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output sweep_stat_t              stat,
    output logic [$clog2(DEPTH)-1:0] addr
);

    localparam int AW = $clog2(DEPTH);

    logic          active_reg;
    logic          active_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic          at_end;

    assign at_end = (cnt_reg == AW'(DEPTH - 1));

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + AW'(1);
            end
        end
    end

    // The sweep runs straight out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.last   = active_reg && at_end;
    assign addr        = cnt_reg;

endmodule
